/* rtl/core/fmfc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fmfc_pkg
// Types, widths and codes shared by the frame memory fit check core.
// ----------------------------------------------------------------------------
package fmfc_pkg;

	// Pixel layout of one frame row
	localparam int unsigned PITCH_ALIGN     = 256;
	localparam int unsigned BYTES_PER_PIXEL = 4;
	localparam int unsigned MIB_BYTES       = 1048576;

	// Field widths
	localparam int unsigned WIDTH_W    = 16;
	localparam int unsigned HEIGHT_W   = 16;
	localparam int unsigned ALIGN_W    = 31;
	localparam int unsigned OFFSET_W   = 40;
	localparam int unsigned COUNT_W    = 8;
	localparam int unsigned CAP_W      = 44;
	localparam int unsigned FSIZE_W    = 36;
	localparam int unsigned REQ_W      = 44;
	localparam int unsigned MIB_W      = 25;
	localparam int unsigned CFG_DATA_W = 44;
	localparam int unsigned CFG_IDX_W  = 2;

	// Internal arithmetic widths
	localparam int unsigned PITCH_W   =
		$clog2((2 ** WIDTH_W - 1) * BYTES_PER_PIXEL + PITCH_ALIGN);
	localparam int unsigned ALLOC_W   = FSIZE_W + 1;
	localparam int unsigned START_W   = OFFSET_W + 1;
	localparam int unsigned PROD_W    = ALLOC_W + COUNT_W;
	localparam int unsigned SUM_W     = PROD_W + 1;
	localparam int unsigned MIB_SHIFT = $clog2(MIB_BYTES);
	localparam int unsigned MIB_LOG   = MIB_W - 1;
	localparam int unsigned NEED_W    = SUM_W - MIB_SHIFT;

	localparam bit PITCH_POW2 = ((PITCH_ALIGN & (PITCH_ALIGN - 1)) == 0);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ALIGNMENT = 2'd0,
		CFG_OFFSET    = 2'd1,
		CFG_COUNT     = 2'd2,
		CFG_CAPACITY  = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		FIT_OK        = 2'd0,
		FIT_INVALID   = 2'd1,
		FIT_TOO_LARGE = 2'd2
	} fit_status_t;

	typedef struct packed {
		logic [WIDTH_W-1:0]  frame_width;
		logic [HEIGHT_W-1:0] frame_height;
	} req_t;

	typedef struct packed {
		fit_status_t        fit_status;
		logic [FSIZE_W-1:0] frame_size;
		logic [REQ_W-1:0]   required_size;
		logic [MIB_W-1:0]   suggested_mib;
	} rsp_t;

	// Configuration as seen by the pipeline
	typedef struct packed {
		logic [ALIGN_W-1:0]  alignment;
		logic [ALIGN_W-1:0]  align_mask;
		logic [OFFSET_W-1:0] memory_offset;
		logic [COUNT_W-1:0]  buffer_count;
		logic [CAP_W-1:0]    capacity;
		logic                ok;
	} cfg_t;

	// Word passed from the allocation half to the totaling half
	typedef struct packed {
		logic               ok;
		logic [FSIZE_W-1:0] frame_size;
		logic [ALLOC_W-1:0] alloc;
		logic [START_W-1:0] start;
	} alloc_t;

endpackage
`default_nettype wire

/* rtl/core/frame_memory_fit_check_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frame_memory_fit_check_core
// Checks whether a requested frame size fits, with its buffers, in
// transport memory and suggests a power-of-two MiB size when it does not.
// ----------------------------------------------------------------------------
// Takes one request word per clock while the result side is not stalled and
// returns one result word per request, in order, from the output register of
// the five-stage pipeline.
// The five register stages are: frame size multiply, alignment rounding,
// buffer count multiply, required size sum, capacity compare and MiB
// suggestion into the output register. Each stage holds its own valid bit and
// takes a new word whenever it is empty or its successor moves, so a stall on
// the result side backs up stage by stage with nothing lost. Registers are
// written through wr_en/wr_index/wr_data and are meant to change only while
// no request is in flight.
module frame_memory_fit_check_core (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             wr_en,
	input  wire logic [fmfc_pkg::CFG_IDX_W-1:0]   wr_index,
	input  wire logic [fmfc_pkg::CFG_DATA_W-1:0]  wr_data,
	input  wire logic                             req_valid,
	output logic                                  req_ready,
	input  wire fmfc_pkg::req_t                   req,
	output logic                                  rsp_valid,
	input  wire logic                             rsp_ready,
	output fmfc_pkg::rsp_t                        rsp
);

	fmfc_pkg::cfg_t    cfg;
	fmfc_pkg::alloc_t  mid;
	logic              mid_valid;
	logic              mid_ready;

	fmfc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	fmfc_alloc u_alloc (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.mid_valid (mid_valid),
		.mid_ready (mid_ready),
		.mid       (mid)
	);

	fmfc_total u_total (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.mid_valid (mid_valid),
		.mid_ready (mid_ready),
		.mid       (mid),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire

/* rtl/core/fmfc_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fmfc_cfg
// Configuration registers and the request-independent validity check.
// ----------------------------------------------------------------------------
module fmfc_cfg (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             wr_en,
	input  wire logic [fmfc_pkg::CFG_IDX_W-1:0]   wr_index,
	input  wire logic [fmfc_pkg::CFG_DATA_W-1:0]  wr_data,
	output fmfc_pkg::cfg_t                        cfg
);

	logic [fmfc_pkg::ALIGN_W-1:0]  alignment_q;
	logic [fmfc_pkg::OFFSET_W-1:0] offset_q;
	logic [fmfc_pkg::COUNT_W-1:0]  count_q;
	logic [fmfc_pkg::CAP_W-1:0]    capacity_q;
	logic [fmfc_pkg::ALIGN_W-1:0]  align_mask;
	logic                          align_pow2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alignment_q <= fmfc_pkg::ALIGN_W'(65536);
			offset_q    <= '0;
			count_q     <= fmfc_pkg::COUNT_W'(2);
			capacity_q  <= '0;
		end else if (wr_en) begin
			unique case (fmfc_pkg::cfg_idx_t'(wr_index))
				fmfc_pkg::CFG_ALIGNMENT: alignment_q <= wr_data[fmfc_pkg::ALIGN_W-1:0];
				fmfc_pkg::CFG_OFFSET:    offset_q    <= wr_data[fmfc_pkg::OFFSET_W-1:0];
				fmfc_pkg::CFG_COUNT:     count_q     <= wr_data[fmfc_pkg::COUNT_W-1:0];
				fmfc_pkg::CFG_CAPACITY:  capacity_q  <= wr_data[fmfc_pkg::CAP_W-1:0];
				default: ;
			endcase
		end
	end

	assign align_mask = alignment_q - fmfc_pkg::ALIGN_W'(1);
	assign align_pow2 = (alignment_q != '0) && ((alignment_q & align_mask) == '0);

	assign cfg.alignment     = alignment_q;
	assign cfg.align_mask    = align_mask;
	assign cfg.memory_offset = offset_q;
	assign cfg.buffer_count  = count_q;
	assign cfg.capacity      = capacity_q;
	assign cfg.ok            = align_pow2 && (offset_q != '0) && (count_q != '0)
		&& fmfc_pkg::PITCH_POW2;

endmodule
`default_nettype wire

/* rtl/core/fmfc_alloc.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fmfc_alloc
// Stages 1-2: frame size from pitch and height, then aligned buffer
// allocation and aligned start offset.
// ----------------------------------------------------------------------------
module fmfc_alloc (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire fmfc_pkg::cfg_t cfg,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire fmfc_pkg::req_t req,
	output logic                mid_valid,
	input  wire logic           mid_ready,
	output fmfc_pkg::alloc_t    mid
);

	localparam logic [fmfc_pkg::PITCH_W-1:0] PITCH_MASK =
		fmfc_pkg::PITCH_W'(fmfc_pkg::PITCH_ALIGN - 1);

	logic                          valid_s1, valid_s2;
	logic                          rdy_s1, rdy_s2;
	logic                          ok_s1;
	logic [fmfc_pkg::FSIZE_W-1:0]  fsize_s1;
	fmfc_pkg::alloc_t              mid_s2;

	logic [fmfc_pkg::PITCH_W-1:0]  row_bytes, pitch;
	logic [fmfc_pkg::FSIZE_W-1:0]  fsize_d;
	logic [fmfc_pkg::ALLOC_W-1:0]  amask_a, alloc_d;
	logic [fmfc_pkg::START_W-1:0]  amask_s, start_d;

	assign rdy_s2    = !valid_s2 || mid_ready;
	assign rdy_s1    = !valid_s1 || rdy_s2;
	assign req_ready = rdy_s1;

	// Row pitch rounded up, then one frame
	assign row_bytes = fmfc_pkg::PITCH_W'(req.frame_width)
		* fmfc_pkg::PITCH_W'(fmfc_pkg::BYTES_PER_PIXEL);
	assign pitch     = (row_bytes + PITCH_MASK) & ~PITCH_MASK;
	assign fsize_d   = fmfc_pkg::FSIZE_W'(pitch) * fmfc_pkg::FSIZE_W'(req.frame_height);

	// Allocation is frame plus alignment, rounded up; start is offset rounded up
	assign amask_a = fmfc_pkg::ALLOC_W'(cfg.align_mask);
	assign alloc_d = (fmfc_pkg::ALLOC_W'(fsize_s1) + fmfc_pkg::ALLOC_W'(cfg.alignment)
		+ amask_a) & ~amask_a;
	assign amask_s = fmfc_pkg::START_W'(cfg.align_mask);
	assign start_d = (fmfc_pkg::START_W'(cfg.memory_offset) + amask_s) & ~amask_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (rdy_s1) valid_s1 <= req_valid;
			if (rdy_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && rdy_s1) begin
			ok_s1    <= (req.frame_width != '0) && (req.frame_height != '0);
			fsize_s1 <= fsize_d;
		end
		if (valid_s1 && rdy_s2) begin
			mid_s2.ok         <= ok_s1 && cfg.ok;
			mid_s2.frame_size <= fsize_s1;
			mid_s2.alloc      <= alloc_d;
			mid_s2.start      <= start_d;
		end
	end

	assign mid_valid = valid_s2;
	assign mid       = mid_s2;

	a_hold_s2: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !mid_ready |=> valid_s2 && $stable(mid_s2))
		else $error("stage 2 word dropped or changed under stall");

	a_fill_s1: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> valid_s1)
		else $error("accepted word missing from stage 1");

endmodule
`default_nettype wire

/* rtl/core/fmfc_total.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fmfc_total
// Stages 3-5: buffer product, required size, capacity compare and the
// power-of-two MiB suggestion. Stage 5 is the output register.
// ----------------------------------------------------------------------------
module fmfc_total (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire fmfc_pkg::cfg_t   cfg,
	input  wire logic             mid_valid,
	output logic                  mid_ready,
	input  wire fmfc_pkg::alloc_t mid,
	output logic                  rsp_valid,
	input  wire logic             rsp_ready,
	output fmfc_pkg::rsp_t        rsp
);

	// Or every bit down into all lower positions
	function automatic logic [fmfc_pkg::MIB_LOG-1:0] smear(
		input logic [fmfc_pkg::MIB_LOG-1:0] v
	);
		logic [fmfc_pkg::MIB_LOG-1:0] r;
		r = v;
		for (int k = 1; k < fmfc_pkg::MIB_LOG; k = k * 2) begin
			r = r | (r >> k);
		end
		return r;
	endfunction

	logic                          valid_s3, valid_s4, valid_s5;
	logic                          rdy_s3, rdy_s4, rdy_s5;

	logic                          ok_s3, ok_s4;
	logic [fmfc_pkg::FSIZE_W-1:0]  fsize_s3, fsize_s4;
	logic [fmfc_pkg::START_W-1:0]  start_s3;
	logic [fmfc_pkg::PROD_W-1:0]   prod_s3;
	logic [fmfc_pkg::SUM_W-1:0]    req_s4, reqm1_s4;
	fmfc_pkg::rsp_t                rsp_s5;

	logic [fmfc_pkg::NEED_W-1:0]   need_m1;
	logic                          over_cap;
	logic [fmfc_pkg::MIB_W-1:0]    mib_d;
	logic [fmfc_pkg::REQ_W-1:0]    req_sat;
	fmfc_pkg::rsp_t                rsp_d;

	assign rdy_s5    = !valid_s5 || rsp_ready;
	assign rdy_s4    = !valid_s4 || rdy_s5;
	assign rdy_s3    = !valid_s3 || rdy_s4;
	assign mid_ready = rdy_s3;

	// Stage 5 logic: compare and suggestion from ceil(req / 1 MiB) - 1
	assign over_cap  = req_s4 > fmfc_pkg::SUM_W'(cfg.capacity);
	assign need_m1   = reqm1_s4[fmfc_pkg::SUM_W-1:fmfc_pkg::MIB_SHIFT];
	assign mib_d     = (|need_m1[fmfc_pkg::NEED_W-1:fmfc_pkg::MIB_LOG])
		? (fmfc_pkg::MIB_W'(1) << fmfc_pkg::MIB_LOG)
		: fmfc_pkg::MIB_W'(smear(need_m1[fmfc_pkg::MIB_LOG-1:0])) + fmfc_pkg::MIB_W'(1);
	assign req_sat   = (|req_s4[fmfc_pkg::SUM_W-1:fmfc_pkg::REQ_W])
		? '1 : req_s4[fmfc_pkg::REQ_W-1:0];

	always_comb begin
		rsp_d = '0;
		priority if (!ok_s4) begin
			rsp_d.fit_status = fmfc_pkg::FIT_INVALID;
		end else if (over_cap) begin
			rsp_d.fit_status    = fmfc_pkg::FIT_TOO_LARGE;
			rsp_d.frame_size    = fsize_s4;
			rsp_d.required_size = req_sat;
			rsp_d.suggested_mib = mib_d;
		end else begin
			rsp_d.fit_status    = fmfc_pkg::FIT_OK;
			rsp_d.frame_size    = fsize_s4;
			rsp_d.required_size = req_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (rdy_s3) valid_s3 <= mid_valid;
			if (rdy_s4) valid_s4 <= valid_s3;
			if (rdy_s5) valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (mid_valid && rdy_s3) begin
			ok_s3    <= mid.ok;
			fsize_s3 <= mid.frame_size;
			start_s3 <= mid.start;
			prod_s3  <= fmfc_pkg::PROD_W'(mid.alloc) * fmfc_pkg::PROD_W'(cfg.buffer_count);
		end
		if (valid_s3 && rdy_s4) begin
			ok_s4    <= ok_s3;
			fsize_s4 <= fsize_s3;
			req_s4   <= fmfc_pkg::SUM_W'(start_s3) + fmfc_pkg::SUM_W'(prod_s3);
			reqm1_s4 <= fmfc_pkg::SUM_W'(start_s3) + fmfc_pkg::SUM_W'(prod_s3)
				- fmfc_pkg::SUM_W'(1);
		end
		if (valid_s4 && rdy_s5) begin
			rsp_s5 <= rsp_d;
		end
	end

	assign rsp_valid = valid_s5;
	assign rsp       = rsp_s5;

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.fit_status == fmfc_pkg::FIT_INVALID |->
			rsp.frame_size == '0 && rsp.required_size == '0 && rsp.suggested_mib == '0)
		else $error("invalid result carries nonzero fields");

	a_large_pow2: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.fit_status == fmfc_pkg::FIT_TOO_LARGE |-> $onehot(rsp.suggested_mib))
		else $error("suggestion is not a power of two");

	a_fit_nomib: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.fit_status == fmfc_pkg::FIT_OK |-> rsp.suggested_mib == '0)
		else $error("suggestion given for a fitting request");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && valid_s4 && valid_s5 && !rsp_ready |-> !mid_ready)
		else $error("word taken into a full stalled pipe");

endmodule
`default_nettype wire
